FILE: design/mbe_pkg.sv
// Shared constants and types for the modulus block encryptor.
// No dependencies.
package mbe_pkg;

  localparam int WORD_W  = 32;
  localparam int CHUNK_W = 16;
  localparam int KEEP_W  = 18;
  localparam int NWORDS  = 4;

  localparam logic [7:0] CHK_SEED = 8'hF8;
  localparam logic [7:0] LEN_MASK = 8'h3D;

  localparam logic [2:0] REG_MOD_LO = 3'd0;
  localparam logic [2:0] REG_MOD_HI = 3'd1;
  localparam logic [2:0] REG_MUL_LO = 3'd2;
  localparam logic [2:0] REG_MUL_HI = 3'd3;
  localparam logic [2:0] REG_WHT_LO = 3'd4;
  localparam logic [2:0] REG_WHT_HI = 3'd5;
  localparam logic [2:0] REG_KEY_OK = 3'd6;

  typedef logic [WORD_W-1:0] word_t;

  // item payload carried alongside the word pipelines
  typedef struct packed {
    logic [NWORDS*KEEP_W-1:0] res;
    logic [3:0]               len;
    logic [63:0]              block;
  } side_t;

endpackage

FILE: design/modulus_block_encrypt.sv
// Top level of the modulus block encryptor: config registers, four word pipes, packer.
// Depends on mbe_pkg and mbe_word.
//
// Takes one 8-byte block per cycle while the output is not stalled and returns its
// 11-byte ciphertext: each of the four chained words passes its multiplier, with
// the product registered, and its bit-per-stage remainder pipe; one output register
// follows. The whole pipe holds while the output item waits. fault (m_tuser) flags
// a missing key or a zero modulus; the ciphertext is then zero. Configure only while idle.
module modulus_block_encrypt
  import mbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // plain_block[63:0], valid_bytes[67:64], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // cipher_bytes_low[63:0], cipher_bytes_high[87:64]
  output logic        m_tuser,   // fault
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] mod_lo, mod_hi, mul_lo, mul_hi, wht_lo, wht_hi;
  logic        key_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_lo <= '0;
      mod_hi <= '0;
      mul_lo <= '0;
      mul_hi <= '0;
      wht_lo <= '0;
      wht_hi <= '0;
      key_ok <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOD_LO: mod_lo <= cfg_data;
        REG_MOD_HI: mod_hi <= cfg_data;
        REG_MUL_LO: mul_lo <= cfg_data;
        REG_MUL_HI: mul_hi <= cfg_data;
        REG_WHT_LO: wht_lo <= cfg_data;
        REG_WHT_HI: wht_hi <= cfg_data;
        REG_KEY_OK: key_ok <= cfg_data[0];
        default: ;
      endcase
    end
  end

  word_t mods [0:NWORDS-1];
  word_t muls [0:NWORDS-1];
  word_t whts [0:NWORDS-1];
  assign mods = '{mod_lo[31:0], mod_lo[63:32], mod_hi[31:0], mod_hi[63:32]};
  assign muls = '{mul_lo[31:0], mul_lo[63:32], mul_hi[31:0], mul_hi[63:32]};
  assign whts = '{wht_lo[31:0], wht_lo[63:32], wht_hi[31:0], wht_hi[63:32]};

  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  logic  vin  [0:NWORDS];
  side_t sin  [0:NWORDS];
  word_t prev [0:NWORDS-1];

  assign vin[0]        = s_tvalid;
  assign sin[0].block  = s_tdata[63:0];
  assign sin[0].len    = s_tdata[67:64];
  assign sin[0].res    = '0;
  assign prev[0]       = '0;

  for (genvar n = 0; n < NWORDS; n++) begin : g_word
    word_t x;
    word_t r;
    side_t so;
    logic  vo;
    assign x = whts[n] ^ {16'h0, sin[n].block[n*CHUNK_W +: CHUNK_W]} ^ prev[n];
    mbe_word u_word (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_valid (vin[n]),
      .in_x     (x),
      .mul      (muls[n]),
      .modulus  (mods[n]),
      .in_side  (sin[n]),
      .out_valid(vo),
      .out_rem  (r),
      .out_side (so)
    );
    always_comb begin
      sin[n+1] = so;
      sin[n+1].res[n*KEEP_W +: KEEP_W] = r[KEEP_W-1:0];
    end
    assign vin[n+1]  = vo;
    if (n < NWORDS-1) begin : g_prev
      assign prev[n+1] = {16'h0, r[CHUNK_W-1:0]};
    end
  end

  side_t            fin;
  logic [KEEP_W-1:0] wv [0:NWORDS-1];
  logic [87:0]      stream;
  logic [87:0]      packed_out;
  logic [7:0]       chk;
  logic             bad;

  assign fin = sin[NWORDS];

  always_comb begin
    for (int n = 0; n < NWORDS; n++) begin
      wv[n] = fin.res[n*KEEP_W +: KEEP_W];
    end
    for (int n = 0; n < NWORDS-1; n++) begin
      wv[n] = wv[n] ^ whts[n][KEEP_W-1:0]
            ^ {2'b00, fin.res[(n+1)*KEEP_W +: CHUNK_W]};
    end
    chk = CHK_SEED;
    for (int b = 0; b < 8; b++) begin
      chk = chk ^ fin.block[b*8 +: 8];
    end
    stream = {wv[0][7:0], wv[0][15:8], wv[0][17], wv[0][16],
              wv[1][7:0], wv[1][15:8], wv[1][17], wv[1][16],
              wv[2][7:0], wv[2][15:8], wv[2][17], wv[2][16],
              wv[3][7:0], wv[3][15:8], wv[3][17], wv[3][16],
              chk ^ {4'h0, fin.len} ^ LEN_MASK, chk};
    for (int b = 0; b < 11; b++) begin
      packed_out[b*8 +: 8] = stream[87-8*b -: 8];
    end
    bad = !key_ok || (mods[0] == '0) || (mods[1] == '0) || (mods[2] == '0)
          || (mods[3] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= vin[NWORDS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= bad ? '0 : packed_out;
      m_tuser <= bad;
    end
  end

endmodule

FILE: design/mbe_word.sv
// One word step: registered multiply, then a 32-stage restoring remainder pipe.
// Depends on mbe_pkg.
module mbe_word
  import mbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  in_valid,
  input  word_t in_x,
  input  word_t mul,
  input  word_t modulus,
  input  side_t in_side,
  output logic  out_valid,
  output word_t out_rem,
  output side_t out_side
);

  logic [WORD_W:0]     vld;
  word_t               rem  [0:WORD_W];
  word_t               dvd  [0:WORD_W-1];
  side_t               side [0:WORD_W];
  word_t               prod;

  assign prod = in_x * mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[WORD_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0]  <= '0;
      dvd[0]  <= prod;
      side[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= WORD_W; k++) begin : g_step
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    assign trial = {rem[k-1], dvd[k-1][WORD_W-1]};
    assign diff  = trial - {1'b0, modulus};
    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k]  <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
        side[k] <= side[k-1];
      end
    end
    if (k < WORD_W) begin : g_shift
      always_ff @(posedge clk) begin
        if (advance) begin
          dvd[k] <= {dvd[k-1][WORD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[WORD_W];
  assign out_rem   = rem[WORD_W];
  assign out_side  = side[WORD_W];

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for modulus_block_encrypt: drives plaintext blocks, predicts each
// ciphertext in-bench and compares every result item. Depends on mbe_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import mbe_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // plain_block[63:0], valid_bytes[67:64], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;   // cipher_bytes_low[63:0], cipher_bytes_high[87:64]
  logic        m_tuser;   // fault
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  typedef struct packed {
    logic [87:0] cipher;
    logic        fault;
  } cipher_t;

  modulus_block_encrypt dut (.*);

  logic [63:0] key_regs [0:5];
  logic        key_ok;
  cipher_t     cipher_q [$];
  int          mismatches;
  int          idle_cycles;
  bit          timed_out;
  bit          hold_off;
  int          stall_max;
  int          gap_max;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] key_word(int base, int n);
    logic [63:0] p;
    p = key_regs[base + n / 2];
    return (n % 2) ? p[63:32] : p[31:0];
  endfunction

  function automatic cipher_t encrypt_block(logic [63:0] blk, logic [3:0] len);
    cipher_t     r;
    logic [31:0] w [4];
    logic [31:0] old [4];
    logic [31:0] m, x;
    logic [63:0] prod;
    logic [15:0] prev;
    logic [87:0] bits;
    logic [7:0]  chk;
    logic [7:0]  stream [11];
    bit          bad;
    r = '0;
    bad = !key_ok;
    for (int n = 0; n < 4; n++) if (key_word(0, n) == 0) bad = 1;
    if (bad) begin
      r.fault = 1'b1;
      return r;
    end
    prev = '0;
    for (int n = 0; n < 4; n++) begin
      x = key_word(4, n) ^ {16'h0, blk[16*n +: 16]} ^ {16'h0, prev};
      prod = x * key_word(2, n);
      m = key_word(0, n);
      w[n] = prod[31:0] % m;
      prev = w[n][15:0];
    end
    old = w;
    for (int n = 0; n < 3; n++) w[n] = w[n] ^ key_word(4, n) ^ {16'h0, old[n + 1][15:0]};
    chk = CHK_SEED;
    for (int n = 0; n < 8; n++) chk ^= blk[8*n +: 8];
    bits = {w[0][7:0], w[0][15:8], w[0][17:16], w[1][7:0], w[1][15:8], w[1][17:16],
            w[2][7:0], w[2][15:8], w[2][17:16], w[3][7:0], w[3][15:8], w[3][17:16],
            chk ^ {4'h0, len} ^ LEN_MASK, chk};
    for (int b = 0; b < 11; b++) stream[b] = bits[87 - 8*b -: 8];
    for (int b = 0; b < 11; b++) r.cipher[8*b +: 8] = stream[b];
    return r;
  endfunction

  function automatic int rand_gap(int maxv);
    int d;
    d = $urandom_range(0, 99);
    if (maxv == 0 || d < 60) return 0;
    if (d < 92) return $urandom_range(1, 3);
    return $urandom_range(4, maxv);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_KEY_OK) key_ok = val[0];
    else key_regs[idx] = val;
    @(posedge clk);
  endtask

  // s_tvalid stays high into the next item when there is no gap; drain drops it
  task automatic send_block(logic [63:0] blk, logic [3:0] len);
    int g;
    g = rand_gap(gap_max);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, len, blk};
    cipher_q.push_back(encrypt_block(blk, len));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_edge64;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h1;
      3: return 64'h8000_0000_8000_0000;
      default: return rand64();
    endcase
  endfunction

  task automatic load_key(logic [63:0] ml, logic [63:0] mh, logic [63:0] kl,
                          logic [63:0] kh, logic [63:0] wl, logic [63:0] wh, bit ok);
    write_reg(REG_MOD_LO, ml);
    write_reg(REG_MOD_HI, mh);
    write_reg(REG_MUL_LO, kl);
    write_reg(REG_MUL_HI, kh);
    write_reg(REG_WHT_LO, wl);
    write_reg(REG_WHT_HI, wh);
    write_reg(REG_KEY_OK, {63'h0, ok});
  endtask

  task automatic test_no_key;
    send_block(64'h0123_4567_89AB_CDEF, 4'd8);
    send_block('1, 4'd1);
    drain();
  endtask

  task automatic test_zero_modulus;
    load_key(64'h0000_0005_0000_0000, '1, '1, '1, '1, '1, 1'b1);
    send_block(64'h1111_2222_3333_4444, 4'd4);
    drain();
    write_reg(REG_MOD_LO, '1);
    write_reg(REG_MOD_HI, 64'hFFFF_FFFF_0000_0000);
    send_block(64'hDEAD_BEEF_0000_0001, 4'd2);
    drain();
  endtask

  task automatic test_directed;
    load_key('1, '1, '1, '1, '1, '1, 1'b1);
    send_block('0, 4'd0);
    send_block('1, 4'd15);
    for (int l = 1; l <= 9; l++) send_block(rand64(), l[3:0]);
    drain();
    load_key(64'h0000_0001_0000_0001, 64'h0003_0000_0002_0000, 64'h1, 64'h1, '0, '0, 1'b1);
    send_block('1, 4'd8);
    send_block(64'h5555_AAAA_5555_AAAA, 4'd3);
    drain();
    load_key(64'hFFFF_FFFE_0003_FFFF, 64'h7FFF_FFFF_0001_0000,
             rand64(), rand64(), rand64(), rand64(), 1'b1);
    send_block('0, 4'd12);
    send_block('1, 4'd8);
    send_block(64'h8000_0000_0000_0001, 4'd1);
    drain();
  endtask

  task automatic test_random(int nsets, int per_set);
    for (int s = 0; s < nsets; s++) begin
      load_key(($urandom_range(0, 3) == 0) ? rand_edge64() : rand64(),
               ($urandom_range(0, 3) == 0) ? rand_edge64() : rand64(),
               rand_edge64(), rand_edge64(), rand_edge64(), rand_edge64(),
               $urandom_range(0, 15) != 0);
      gap_max   = (s % 4 == 0) ? 0 : 20;
      stall_max = (s % 5 == 1) ? 0 : 20;
      for (int i = 0; i < per_set; i++)
        send_block(($urandom_range(0, 9) == 0) ? rand_edge64() : rand64(),
                   4'($urandom_range(0, 15)));
      drain();
    end
  endtask

  task automatic test_backpressure;
    load_key(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), 1'b1);
    gap_max = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 250; i++) send_block(rand64(), 4'($urandom_range(1, 8)));
    join
    drain();
  endtask

  always @(posedge clk) begin
    int g;
    cipher_t exp_c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: data %h fault %b", m_tdata, m_tuser);
        end else begin
          exp_c = cipher_q.pop_front();
          if (m_tdata !== exp_c.cipher || m_tuser !== exp_c.fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%b got %h/%b", exp_c.cipher, exp_c.fault,
                       m_tdata, m_tuser);
          end
        end
      end
      g = rand_gap(stall_max);
      m_tready <= !hold_off && (g == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    m_tready = 1'b0; mismatches = 0; idle_cycles = 0; timed_out = 0; hold_off = 0;
    stall_max = 20; gap_max = 20; key_ok = 1'b0;
    for (int i = 0; i < 6; i++) key_regs[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_key();
    test_zero_modulus();
    test_directed();
    test_backpressure();
    test_random(12, 73);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: files.f
design/mbe_pkg.sv
design/mbe_word.sv
design/modulus_block_encrypt.sv
tb/sv/tb_top.sv
